>>> design/ocst_pkg.sv
package ocst_pkg;

  // default width of a character code
  localparam int unsigned CODE_BITS = 8;

  // action codes carried in the input tuser
  localparam logic [2:0] ACT_CLEAR    = 3'd0;
  localparam logic [2:0] ACT_ADD      = 3'd1;
  localparam logic [2:0] ACT_REMOVE   = 3'd2;
  localparam logic [2:0] ACT_CONTAINS = 3'd3;
  localparam logic [2:0] ACT_READ_AT  = 3'd4;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_READ,
    ST_SCAN,
    ST_WIPE,
    ST_DONE
  } state_t;

endpackage

>>> design/ordered_char_set_table.sv
// Ordered character set: a membership bitmap and a list of the members in insertion order,
// each held in a registered-read RAM of 2**CODE_BITS entries. One operation is taken per input
// transfer, chosen by s_tuser (clear, add, remove, contains, read_at; unknown codes act as
// contains), and exactly one result comes back on the m_ side, held in an output register so
// the next input can be taken while it waits. After reset the bitmap is wiped one entry per
// cycle, and s_tready first rises once the whole bitmap has been wiped. A read_at within the
// list makes one list RAM read; a clear wipes the bitmap again; a remove of a present code
// walks the list through the list RAM read port one entry per cycle, a single comparator
// finds the code, and each later entry is written back one place lower. No input is taken
// until the current result has been loaded for output.
module ordered_char_set_table #(
  parameter int unsigned CODE_BITS = ocst_pkg::CODE_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // char_code[7:0], position[15:8]
  input  logic [2:0]  s_tuser,   // action[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // was_present[0], char_out[8:1], member_count[17:9], zeros
);

  localparam int unsigned CODE_SPACE = 1 << CODE_BITS;
  localparam int unsigned CNT_BITS   = CODE_BITS + 1;
  localparam int unsigned WIDE       = (CNT_BITS > 9) ? CNT_BITS : 9;

  ocst_pkg::state_t state, state_next;

  logic [2:0]            act;
  logic [CODE_BITS-1:0]  code;
  logic [WIDE-1:0]       pos;
  logic                  present;
  logic [CODE_BITS-1:0]  ch;
  logic [CNT_BITS-1:0]   count;
  logic [CODE_BITS-1:0]  wipe_idx;
  logic                  op_live;
  logic [CNT_BITS-1:0]   scan_idx;
  logic [CNT_BITS-1:0]   data_idx;
  logic                  data_valid;
  logic                  found;

  logic       out_valid;
  logic       out_present;
  logic [7:0] out_ch;
  logic [8:0] out_count;

  // input fields brought to WIDE bits, and the code to code width
  logic [WIDE-1:0]      code_wide;
  logic [WIDE-1:0]      pos_wide;
  logic [CODE_BITS-1:0] in_code;
  logic                 accept;
  logic                 issue;
  logic                 scan_end;
  logic                 wipe_end;
  logic                 out_load;
  logic [CNT_BITS-1:0]  prev_idx;
  logic [WIDE-1:0]      ch_wide;
  logic [WIDE-1:0]      count_wide;

  // list ram port
  logic                 ram_we;
  logic [CODE_BITS-1:0] ram_waddr;
  logic [CODE_BITS-1:0] ram_wdata;
  logic [CODE_BITS-1:0] ram_raddr;
  logic [CODE_BITS-1:0] ram_rdata;

  // bitmap ram port
  logic                 bit_we;
  logic [CODE_BITS-1:0] bit_waddr;
  logic                 bit_wdata;
  logic [CODE_BITS-1:0] bit_raddr;
  logic                 bit_rdata;

  assign code_wide  = WIDE'(s_tdata[7:0]);
  assign pos_wide   = WIDE'(s_tdata[15:8]);
  assign in_code    = code_wide[CODE_BITS-1:0];
  assign s_tready   = (state == ocst_pkg::ST_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign issue      = (scan_idx < count);
  assign scan_end   = !issue && !data_valid;
  assign wipe_end   = (wipe_idx == '1);
  assign out_load   = (state == ocst_pkg::ST_DONE) && (!out_valid || m_tready);
  assign prev_idx   = data_idx - 1'b1;
  assign ch_wide    = WIDE'(ch);
  assign count_wide = WIDE'(count);

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_count, out_ch, out_present};

  ocst_ram #(
    .WIDTH (CODE_BITS),
    .DEPTH (CODE_SPACE)
  ) u_list (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ocst_ram #(
    .WIDTH (1),
    .DEPTH (CODE_SPACE)
  ) u_bits (
    .clk   (clk),
    .we    (bit_we),
    .waddr (bit_waddr),
    .wdata (bit_wdata),
    .raddr (bit_raddr),
    .rdata (bit_rdata)
  );

  // state register, reset starts with a wipe of the bitmap
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ocst_pkg::ST_WIPE;
    end else begin
      state <= state_next;
    end
  end

  // next state and ram control
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = count[CODE_BITS-1:0];
    ram_wdata  = code;
    ram_raddr  = pos[CODE_BITS-1:0];
    bit_we     = 1'b0;
    bit_waddr  = code;
    bit_wdata  = 1'b0;
    bit_raddr  = in_code;
    unique case (state)
      ocst_pkg::ST_WIPE: begin
        bit_we    = 1'b1;
        bit_waddr = wipe_idx;
        if (wipe_end) begin
          state_next = op_live ? ocst_pkg::ST_DONE : ocst_pkg::ST_IDLE;
        end
      end
      ocst_pkg::ST_IDLE: begin
        // bitmap read of the incoming code
        if (accept) begin
          state_next = ocst_pkg::ST_LOOK;
        end
      end
      ocst_pkg::ST_LOOK: begin
        state_next = ocst_pkg::ST_DONE;
        case (act)
          ocst_pkg::ACT_CLEAR: begin
            state_next = ocst_pkg::ST_WIPE;
          end
          ocst_pkg::ACT_ADD: begin
            if (!bit_rdata) begin
              bit_we    = 1'b1;
              bit_wdata = 1'b1;
              ram_we    = 1'b1;
            end
          end
          ocst_pkg::ACT_REMOVE: begin
            if (bit_rdata) begin
              bit_we     = 1'b1;
              state_next = ocst_pkg::ST_SCAN;
            end
          end
          ocst_pkg::ACT_READ_AT: begin
            if (pos < count_wide) begin
              state_next = ocst_pkg::ST_READ;
            end
          end
          default: ;
        endcase
      end
      ocst_pkg::ST_READ: begin
        state_next = ocst_pkg::ST_DONE;
      end
      ocst_pkg::ST_SCAN: begin
        // read ahead while the returned entry is shifted down
        ram_raddr = scan_idx[CODE_BITS-1:0];
        ram_we    = data_valid && found;
        ram_waddr = prev_idx[CODE_BITS-1:0];
        ram_wdata = ram_rdata;
        if (scan_end) begin
          state_next = ocst_pkg::ST_DONE;
        end
      end
      ocst_pkg::ST_DONE: begin
        if (out_load) begin
          state_next = ocst_pkg::ST_IDLE;
        end
      end
      default: state_next = ocst_pkg::ST_IDLE;
    endcase
  end

  // member count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (state == ocst_pkg::ST_LOOK) begin
      case (act)
        ocst_pkg::ACT_CLEAR: begin
          count <= '0;
        end
        ocst_pkg::ACT_ADD: begin
          if (!bit_rdata) begin
            count <= count + 1'b1;
          end
        end
        default: ;
      endcase
    end else if (state == ocst_pkg::ST_SCAN && scan_end) begin
      count <= count - 1'b1;
    end
  end

  // operation context, bitmap wipe and list scan
  always_ff @(posedge clk) begin
    if (rst) begin
      op_live    <= 1'b0;
      data_valid <= 1'b0;
      found      <= 1'b0;
      scan_idx   <= '0;
      wipe_idx   <= '0;
    end else begin
      if (accept) begin
        op_live    <= 1'b1;
        act        <= s_tuser;
        code       <= in_code;
        pos        <= pos_wide;
        ch         <= '0;
        data_valid <= 1'b0;
        found      <= 1'b0;
        scan_idx   <= '0;
      end
      if (state == ocst_pkg::ST_LOOK) begin
        present <= bit_rdata;
      end
      if (state == ocst_pkg::ST_WIPE) begin
        wipe_idx <= wipe_idx + 1'b1;
      end
      if (state == ocst_pkg::ST_READ) begin
        ch <= ram_rdata;
      end
      if (state == ocst_pkg::ST_SCAN) begin
        data_valid <= issue;
        data_idx   <= scan_idx;
        if (issue) begin
          scan_idx <= scan_idx + 1'b1;
        end
        if (data_valid && ram_rdata == code && act == ocst_pkg::ACT_REMOVE) begin
          found <= 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_present <= present;
      out_ch      <= ch_wide[7:0];
      out_count   <= count_wide[8:0];
    end
  end

endmodule

>>> design/ocst_ram.sv
module ocst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
